// File: sv/qrs_pkg.sv
// Shared types and constants for the quadratic root solver.
// No dependencies; imported by every module of the block.
`default_nettype none

package qrs_pkg;

	// Width of the root result words and of the discriminant word.
	localparam int ROOT_W = 40;
	localparam int DISC_W = 34;

	// Result classification.
	typedef enum logic [1:0] {
		ST_NOT_QUAD = 2'd0,
		ST_NO_ROOT  = 2'd1,
		ST_DOUBLE   = 2'd2,
		ST_TWO      = 2'd3
	} status_t;

	// Per-cycle pipeline control handed to each pipelined unit.
	typedef struct packed {
		logic en;
		logic vld;
	} pipe_ctl_t;

endpackage

`default_nettype wire

// File: sv/qrs_sqrt.sv
// Pipelined integer square root, one root bit resolved per register stage.
// Depends on qrs_pkg for the pipeline control struct.
`default_nettype none

module qrs_sqrt #(
	parameter int IW  = 66,
	parameter int SBW = 8
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire qrs_pkg::pipe_ctl_t ctl,
	input  wire logic [IW-1:0]      x,
	input  wire logic [SBW-1:0]     sb_in,
	output logic                    vld_out,
	output logic [IW/2-1:0]         root,
	output logic [SBW-1:0]          sb_out
);
	import qrs_pkg::*;

	localparam int RW = IW / 2;
	localparam int MW = RW + 2;

	logic [IW-1:0]  x_s    [0:RW];
	logic [MW-1:0]  rem_s  [0:RW];
	logic [RW-1:0]  root_s [0:RW];
	logic [SBW-1:0] sb_s   [0:RW];
	logic           vld_s  [0:RW];

	// Stage zero is the input word itself.
	assign x_s[0]    = x;
	assign rem_s[0]  = '0;
	assign root_s[0] = '0;
	assign sb_s[0]   = sb_in;
	assign vld_s[0]  = ctl.vld;

	for (genvar k = 0; k < RW; k++) begin : g_stage
		logic [MW-1:0] rem_sh;
		logic [MW-1:0] trial;
		logic          ge;
		logic [MW-1:0] rem_nx;

		// Bring down the next bit pair and try the next root bit.
		always_comb begin
			rem_sh = {rem_s[k][MW-3:0], x_s[k][IW-1 -: 2]};
			trial  = {root_s[k], 2'b01};
			ge     = (rem_sh >= trial);
			rem_nx = ge ? (rem_sh - trial) : rem_sh;
		end

		// Valid bit of the stage.
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[k+1] <= 1'b0;
			end else if (ctl.en) begin
				vld_s[k+1] <= vld_s[k];
			end
		end

		// Data of the stage.
		always_ff @(posedge clk) begin
			if (ctl.en) begin
				x_s[k+1]    <= {x_s[k][IW-3:0], 2'b00};
				rem_s[k+1]  <= rem_nx;
				root_s[k+1] <= {root_s[k][RW-2:0], ge};
				sb_s[k+1]   <= sb_s[k];
			end
		end
	end

	assign vld_out = vld_s[RW];
	assign root    = root_s[RW];
	assign sb_out  = sb_s[RW];

endmodule

`default_nettype wire

// File: sv/qrs_div.sv
// Pipelined unsigned restoring divider, one quotient bit per register stage.
// Depends on qrs_pkg for the pipeline control struct.
`default_nettype none

module qrs_div #(
	parameter int NW  = 34,
	parameter int DVW = 17,
	parameter int SBW = 8
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire qrs_pkg::pipe_ctl_t ctl,
	input  wire logic [NW-1:0]      num,
	input  wire logic [DVW-1:0]     den,
	input  wire logic [SBW-1:0]     sb_in,
	output logic                    vld_out,
	output logic [NW-1:0]           quo,
	output logic [SBW-1:0]          sb_out
);
	import qrs_pkg::*;

	logic [NW-1:0]  n_s   [0:NW];
	logic [DVW-1:0] d_s   [0:NW];
	logic [DVW:0]   rem_s [0:NW];
	logic [NW-1:0]  q_s   [0:NW];
	logic [SBW-1:0] sb_s  [0:NW];
	logic           vld_s [0:NW];

	assign n_s[0]   = num;
	assign d_s[0]   = den;
	assign rem_s[0] = '0;
	assign q_s[0]   = '0;
	assign sb_s[0]  = sb_in;
	assign vld_s[0] = ctl.vld;

	for (genvar k = 0; k < NW; k++) begin : g_stage
		logic [DVW:0] rem_sh;
		logic         ge;
		logic [DVW:0] rem_nx;

		// Shift in the next dividend bit and subtract when it fits.
		always_comb begin
			rem_sh = {rem_s[k][DVW-1:0], n_s[k][NW-1]};
			ge     = (rem_sh >= {1'b0, d_s[k]});
			rem_nx = ge ? (rem_sh - {1'b0, d_s[k]}) : rem_sh;
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[k+1] <= 1'b0;
			end else if (ctl.en) begin
				vld_s[k+1] <= vld_s[k];
			end
		end

		always_ff @(posedge clk) begin
			if (ctl.en) begin
				n_s[k+1]   <= {n_s[k][NW-2:0], 1'b0};
				d_s[k+1]   <= d_s[k];
				rem_s[k+1] <= rem_nx;
				q_s[k+1]   <= {q_s[k][NW-2:0], ge};
				sb_s[k+1]  <= sb_s[k];
			end
		end
	end

	assign vld_out = vld_s[NW];
	assign quo     = q_s[NW];
	assign sb_out  = sb_s[NW];

endmodule

`default_nettype wire

// File: sv/quadratic_root_solver.sv
// Quadratic root solver: registers run stage 1, stage 2, the bit-per-stage square root, stage 3,
// the bit-per-stage dividers and the output register; RW is the root width and NW the divider width.
// Throughput is one word per cycle unless the output stalls; a stall at the output freezes the whole pipeline.
// Reset clears only the valid bits; no clearing pass, words are accepted at once.
// Depends on qrs_pkg, qrs_sqrt and qrs_div.
`default_nettype none

module quadratic_root_solver #(
	parameter int COEF_WIDTH = 16,
	parameter int FRAC_BITS  = 16
) (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	input  wire logic                                in_valid,
	output logic                                     in_stall,
	input  wire logic signed [COEF_WIDTH-1:0]        coef_a,
	input  wire logic signed [COEF_WIDTH-1:0]        coef_b,
	input  wire logic signed [COEF_WIDTH-1:0]        coef_c,
	output logic                                     out_valid,
	input  wire logic                                out_stall,
	output logic [1:0]                               status,
	output logic signed [qrs_pkg::ROOT_W-1:0]        root_plus,
	output logic signed [qrs_pkg::ROOT_W-1:0]        root_minus,
	output logic signed [qrs_pkg::DISC_W-1:0]        discriminant
);
	import qrs_pkg::*;

	localparam int CW      = COEF_WIDTH;
	localparam int F       = FRAC_BITS;
	localparam int PW      = 2 * CW;
	localparam int DW_FULL = 2 * CW + 3;
	localparam int DW      = (DW_FULL > 64) ? 64 : DW_FULL;
	localparam int IW      = 2 * ((DW + 2 * F) / 2);
	localparam int RW      = IW / 2;
	localparam int BW      = CW + 1 + F;
	localparam int NW      = ((BW > RW) ? BW : RW) + 1;
	localparam int DVW     = CW + 1;
	localparam int QSW     = (NW + 1 > ROOT_W) ? NW + 1 : ROOT_W;
	localparam int DXW     = (DW > DISC_W) ? DW : DISC_W;
	localparam int SQ_SBW  = 2 + DISC_W + 2 * CW;
	localparam int DV_SBW  = 2 + DISC_W + 1;

	// Global advance: the pipeline moves unless a finished word is held at the output.
	logic      en;
	pipe_ctl_t sq_ctl;
	pipe_ctl_t dv_ctl;
	logic      out_vld_q;

	assign en       = !(out_vld_q && out_stall);
	assign in_stall = !en;

	// Stage 1: the two products.
	logic                 vld_s1;
	logic signed [CW-1:0] a_s1;
	logic signed [CW-1:0] b_s1;
	logic signed [PW-1:0] bb_s1;
	logic signed [PW-1:0] ac_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (en) begin
			vld_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			a_s1  <= coef_a;
			b_s1  <= coef_b;
			bb_s1 <= coef_b * coef_b;
			ac_s1 <= coef_a * coef_c;
		end
	end

	// Stage 2: discriminant and classification.
	logic signed [DW-1:0]  du;
	logic signed [DXW-1:0] du_x;
	logic                  a_zero;
	status_t               st_c;
	logic                  vld_s2;
	status_t               status_s2;
	logic [DISC_W-1:0]     disc_s2;
	logic signed [CW-1:0]  a_s2;
	logic signed [CW-1:0]  b_s2;
	logic [IW-1:0]         x_s2;

	always_comb begin
		du     = DW'(bb_s1) - (DW'(ac_s1) <<< 2);
		du_x   = DXW'(du);
		a_zero = (a_s1 == '0);
		if (a_zero) begin
			st_c = ST_NOT_QUAD;
		end else if (du[DW-1]) begin
			st_c = ST_NO_ROOT;
		end else if (du == '0) begin
			st_c = ST_DOUBLE;
		end else begin
			st_c = ST_TWO;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s2 <= 1'b0;
		end else if (en) begin
			vld_s2 <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			status_s2 <= st_c;
			disc_s2   <= a_zero ? '0 : du_x[DISC_W-1:0];
			a_s2      <= a_s1;
			b_s2      <= b_s1;
			x_s2      <= (a_zero || du[DW-1]) ? '0 : (IW'($unsigned(du)) << (2 * F));
		end
	end

	// Square root of the scaled discriminant.
	logic              sq_vld;
	logic [RW-1:0]     sq_root;
	logic [SQ_SBW-1:0] sq_sb;

	assign sq_ctl = '{en: en, vld: vld_s2};

	qrs_sqrt #(
		.IW  (IW),
		.SBW (SQ_SBW)
	) u_sqrt (
		.clk     (clk),
		.arst_n  (arst_n),
		.ctl     (sq_ctl),
		.x       (x_s2),
		.sb_in   ({status_s2, disc_s2, a_s2, b_s2}),
		.vld_out (sq_vld),
		.root    (sq_root),
		.sb_out  (sq_sb)
	);

	// Stage 3: numerators, signs and divisor magnitude.
	status_t              sq_st;
	logic [DISC_W-1:0]    sq_disc;
	logic signed [CW-1:0] sq_a;
	logic signed [CW-1:0] sq_b;
	logic signed [NW-1:0] base;
	logic signed [NW-1:0] np;
	logic signed [NW-1:0] nm;
	logic signed [DVW-1:0] a_ext;
	logic [DVW-1:0]       a_abs;
	logic                 vld_s3;
	logic [NW-1:0]        np_mag_s3;
	logic [NW-1:0]        nm_mag_s3;
	logic [DVW-1:0]       den_s3;
	logic                 negp_s3;
	logic                 negm_s3;
	status_t              status_s3;
	logic [DISC_W-1:0]    disc_s3;

	always_comb begin
		sq_st   = status_t'(sq_sb[SQ_SBW-1 -: 2]);
		sq_disc = sq_sb[2*CW +: DISC_W];
		sq_a    = sq_sb[CW +: CW];
		sq_b    = sq_sb[CW-1:0];
		base    = -(NW'(sq_b)) <<< F;
		np      = base + $signed(NW'(sq_root));
		nm      = base - $signed(NW'(sq_root));
		a_ext   = DVW'(sq_a);
		a_abs   = a_ext[DVW-1] ? DVW'(-a_ext) : DVW'(a_ext);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s3 <= 1'b0;
		end else if (en) begin
			vld_s3 <= sq_vld;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			np_mag_s3 <= np[NW-1] ? NW'(-np) : NW'(np);
			nm_mag_s3 <= nm[NW-1] ? NW'(-nm) : NW'(nm);
			den_s3    <= {a_abs[DVW-2:0], 1'b0};
			negp_s3   <= np[NW-1] ^ sq_a[CW-1];
			negm_s3   <= nm[NW-1] ^ sq_a[CW-1];
			status_s3 <= sq_st;
			disc_s3   <= sq_disc;
		end
	end

	// Two dividers, one per root; the plus side carries the result fields.
	logic              dv_vld_p;
	logic              dv_vld_m;
	logic [NW-1:0]     qp;
	logic [NW-1:0]     qm;
	logic [DV_SBW-1:0] dv_sb;
	logic              dv_negm;

	assign dv_ctl = '{en: en, vld: vld_s3};

	qrs_div #(
		.NW  (NW),
		.DVW (DVW),
		.SBW (DV_SBW)
	) u_div_plus (
		.clk     (clk),
		.arst_n  (arst_n),
		.ctl     (dv_ctl),
		.num     (np_mag_s3),
		.den     (den_s3),
		.sb_in   ({status_s3, disc_s3, negp_s3}),
		.vld_out (dv_vld_p),
		.quo     (qp),
		.sb_out  (dv_sb)
	);

	qrs_div #(
		.NW  (NW),
		.DVW (DVW),
		.SBW (1)
	) u_div_minus (
		.clk     (clk),
		.arst_n  (arst_n),
		.ctl     (dv_ctl),
		.num     (nm_mag_s3),
		.den     (den_s3),
		.sb_in   (negm_s3),
		.vld_out (dv_vld_m),
		.quo     (qm),
		.sb_out  (dv_negm)
	);

	// Output register: restore signs and zero the roots where there are none.
	status_t               dv_st;
	logic                  roots_ok;
	logic signed [QSW-1:0] qp_x;
	logic signed [QSW-1:0] qm_x;
	logic signed [QSW-1:0] rp;
	logic signed [QSW-1:0] rm;
	status_t               status_q;
	logic [ROOT_W-1:0]     root_plus_q;
	logic [ROOT_W-1:0]     root_minus_q;
	logic [DISC_W-1:0]     disc_q;

	always_comb begin
		dv_st    = status_t'(dv_sb[DV_SBW-1 -: 2]);
		roots_ok = (dv_st == ST_DOUBLE) || (dv_st == ST_TWO);
		qp_x     = $signed(QSW'(qp));
		qm_x     = $signed(QSW'(qm));
		rp       = dv_sb[0] ? -qp_x : qp_x;
		rm       = dv_negm ? -qm_x : qm_x;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else if (en) begin
			out_vld_q <= dv_vld_p;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			status_q     <= dv_st;
			root_plus_q  <= roots_ok ? rp[ROOT_W-1:0] : '0;
			root_minus_q <= roots_ok ? rm[ROOT_W-1:0] : '0;
			disc_q       <= dv_sb[1 +: DISC_W];
		end
	end

	assign out_valid    = out_vld_q;
	assign status       = status_q;
	assign root_plus    = root_plus_q;
	assign root_minus   = root_minus_q;
	assign discriminant = disc_q;

`ifndef SYNTH
	// Both dividers must stay in lockstep.
	a_div_lockstep: assert property (@(posedge clk) disable iff (!arst_n)
		dv_vld_p == dv_vld_m)
		else $error("root dividers out of step");

	// A non-quadratic word carries no discriminant and no roots.
	a_not_quad_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (status == ST_NOT_QUAD) |->
			(discriminant == '0) && (root_plus == '0) && (root_minus == '0))
		else $error("non-quadratic word with nonzero fields");

	// A double root gives equal roots.
	a_double_equal: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (status == ST_DOUBLE) |-> (root_plus == root_minus))
		else $error("double root with differing roots");

	// A held output word freezes the input side in the same cycle.
	a_stall_path: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall == (out_valid && out_stall))
		else $error("input stall does not follow the held output word");
`endif

endmodule

`default_nettype wire

// File: sim/quadratic_root_solver_test.sv
// Testbench for the quadratic root solver: drives coefficient words, predicts
// each result in SystemVerilog and compares it field by field. Depends on qrs_pkg and quadratic_root_solver.
`timescale 1ns / 100ps
`default_nettype none

module quadratic_root_solver_test;
	import qrs_pkg::*;

	localparam int CW = 16;
	localparam int FB = 16;
	localparam int PIPE_LAT = 71;

	typedef struct packed {
		status_t             st;
		logic signed [39:0]  rp;
		logic signed [39:0]  rm;
		logic signed [33:0]  disc;
	} root_word_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_stall;
	logic signed [CW-1:0] coef_a = '0;
	logic signed [CW-1:0] coef_b = '0;
	logic signed [CW-1:0] coef_c = '0;
	logic out_valid;
	logic out_stall = 1'b0;
	logic [1:0] status;
	logic signed [ROOT_W-1:0] root_plus;
	logic signed [ROOT_W-1:0] root_minus;
	logic signed [DISC_W-1:0] discriminant;

	root_word_t expected_roots[$];
	int mismatches = 0;
	bit stall_enable = 1'b1;

	quadratic_root_solver #(.COEF_WIDTH(CW), .FRAC_BITS(FB)) dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall),
		.coef_a(coef_a), .coef_b(coef_b), .coef_c(coef_c),
		.out_valid(out_valid), .out_stall(out_stall),
		.status(status), .root_plus(root_plus), .root_minus(root_minus),
		.discriminant(discriminant)
	);

	always #10 clk = ~clk;

	// Floor of sqrt(d * 2^(2*FB)), digit by digit.
	function automatic longint unsigned fixed_root(longint unsigned d);
		logic [127:0] arg;
		logic [127:0] rem;
		logic [127:0] root;
		logic [127:0] trial;
		arg = {64'd0, d} << (2 * FB);
		rem = '0;
		root = '0;
		for (int i = 63; i >= 0; i--) begin
			rem = (rem << 2) | ((arg >> (2 * i)) & 128'd3);
			trial = (root << 2) | 128'd1;
			if (rem >= trial) begin
				rem = rem - trial;
				root = (root << 1) | 128'd1;
			end else begin
				root = root << 1;
			end
		end
		return root[63:0];
	endfunction

	// Expected result word for one coefficient set.
	function automatic root_word_t solve_roots(logic signed [CW-1:0] a,
			logic signed [CW-1:0] b, logic signed [CW-1:0] c);
		root_word_t w;
		longint sa, sb, sc, d, s, base, den;
		sa = longint'(a);
		sb = longint'(b);
		sc = longint'(c);
		w = '{st: ST_NOT_QUAD, rp: '0, rm: '0, disc: '0};
		if (sa == 0)
			return w;
		d = sb * sb - 4 * sa * sc;
		w.disc = d[33:0];
		if (d < 0) begin
			w.st = ST_NO_ROOT;
			return w;
		end
		s = longint'(fixed_root(d));
		base = -sb * (longint'(1) << FB);
		den = 2 * sa;
		w.st = (d == 0) ? ST_DOUBLE : ST_TWO;
		w.rp = 40'((base + s) / den);
		w.rm = 40'((base - s) / den);
		return w;
	endfunction

	// Sends one coefficient word and records its expected result.
	task automatic send_coefs(logic signed [CW-1:0] a, logic signed [CW-1:0] b,
			logic signed [CW-1:0] c);
		in_valid <= 1'b1;
		coef_a <= a;
		coef_b <= b;
		coef_c <= c;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		expected_roots.push_back(solve_roots(a, b, c));
	endtask

	task automatic idle_sender(int n);
		in_valid <= 1'b0;
		repeat (n) @(posedge clk);
	endtask

	task automatic wait_drained();
		in_valid <= 1'b0;
		while (expected_roots.size() != 0)
			@(posedge clk);
	endtask

	// Extremes of the fields and every status.
	task automatic test_directed();
		send_coefs(0, 5, 7);
		send_coefs(0, -32768, 32767);
		send_coefs(1, 0, 1);
		send_coefs(32767, 0, 32767);
		send_coefs(1, 2, 1);
		send_coefs(-1, 2, -1);
		send_coefs(1, 0, 0);
		send_coefs(1, -3, 2);
		send_coefs(-32768, -32768, -32768);
		send_coefs(-32768, 32767, 32767);
		send_coefs(32767, -32768, -32768);
		send_coefs(32767, 32767, 32767);
		send_coefs(-32768, 0, 32767);
		send_coefs(1, -32768, 0);
		send_coefs(2, 3, -5);
		send_coefs(-1, -1, -1);
		send_coefs(3, 7, 0);
		send_coefs(16384, -32768, 16384);
	endtask

	// Random coefficients, biased toward real roots and small values.
	task automatic test_random(int count);
		logic signed [CW-1:0] a, b, c;
		int burst;
		int sent;
		sent = 0;
		while (sent < count) begin
			burst = $urandom_range(1, 40);
			for (int k = 0; k < burst && sent < count; k++) begin
				a = CW'($urandom);
				b = CW'($urandom);
				c = CW'($urandom);
				case ($urandom_range(0, 5))
					0: a = 0;
					1: c = CW'(-a * $urandom_range(0, 3));
					2: begin
						a = CW'($signed(CW'($urandom_range(0, 15))) - 8);
						b = CW'($signed(CW'($urandom_range(0, 63))) - 32);
						c = CW'($signed(CW'($urandom_range(0, 15))) - 8);
					end
					3: begin
						// Perfect square: a(x+r)^2 gives a double root when a is nonzero.
						a = CW'($signed(CW'($urandom_range(1, 64))) - 32);
						b = CW'(2 * a * ($signed(CW'($urandom_range(0, 20))) - 10));
						c = CW'((b / 2) * (b / 2) / (a == 0 ? 1 : a));
					end
					default: ;
				endcase
				send_coefs(a, b, c);
				sent++;
			end
			if ($urandom_range(0, 2) != 0)
				idle_sender($urandom_range(1, 8));
		end
	endtask

	// Pause until every result has come, then keep going.
	task automatic test_drain_pause();
		wait_drained();
		test_random(50);
	endtask

	// Full-rate traffic with the receiver never stalling.
	task automatic test_no_stall();
		stall_enable = 1'b0;
		for (int k = 0; k < 100; k++)
			send_coefs(CW'($urandom), CW'($urandom), CW'($urandom));
		stall_enable = 1'b1;
	endtask

	// Receiver stall pattern: out_stall toggles at random, giving runs of readiness and runs of stall alike.
	always @(posedge clk) begin
		if (!stall_enable)
			out_stall <= 1'b0;
		else if ($urandom_range(0, 9) < 3)
			out_stall <= ~out_stall;
	end

	// Checks each accepted result word against the oldest expectation.
	always @(posedge clk) begin
		root_word_t exp_w;
		if (arst_n && out_valid && !out_stall) begin
			if (expected_roots.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected result word: status %0d", status);
			end else begin
				exp_w = expected_roots.pop_front();
				if (status !== exp_w.st || root_plus !== exp_w.rp ||
						root_minus !== exp_w.rm || discriminant !== exp_w.disc) begin
					mismatches++;
					if (mismatches <= 10)
						$display("mismatch: exp st %0d rp %0d rm %0d d %0d, got %0d %0d %0d %0d",
							exp_w.st, exp_w.rp, exp_w.rm, exp_w.disc,
							status, root_plus, root_minus, discriminant);
				end
			end
		end
	end

	initial begin
		int guard;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_random(350);
		test_drain_pause();
		test_no_stall();
		test_random(300);
		in_valid <= 1'b0;
		guard = 0;
		while (expected_roots.size() != 0 && guard < 100000) begin
			@(posedge clk);
			guard++;
		end
		repeat (PIPE_LAT + 10) @(posedge clk);
		if (mismatches == 0 && expected_roots.size() == 0)
			$display("PASSED: all results match");
		else
			$display("FAILED: results differ");
		$finish;
	end

	initial begin
		#2ms;
		$display("FAILED: results differ");
		$finish;
	end

endmodule

`default_nettype wire

// File: sim.f
sv/qrs_pkg.sv
sv/qrs_sqrt.sv
sv/qrs_div.sv
sv/quadratic_root_solver.sv
sim/quadratic_root_solver_test.sv
